[sv/i2cwbi_pkg.sv]
// Shared types and constants for the I2C write-bit injector.
package i2cwbi_pkg;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_TARGET_ADDRESS  = 3'd0;
  localparam logic [2:0] REG_TARGET_REGISTER = 3'd1;
  localparam logic [2:0] REG_INJECT_POS      = 3'd2;
  localparam logic [2:0] REG_ACK_DELAY       = 3'd3;
  localparam logic [2:0] REG_TIMEOUT         = 3'd4;

  localparam logic [7:0]  RST_TARGET_ADDRESS  = 8'h88;
  localparam logic [7:0]  RST_TARGET_REGISTER = 8'h00;
  localparam logic [2:0]  RST_INJECT_POS      = 3'd7;
  localparam logic [15:0] RST_ACK_DELAY       = 16'd150;
  localparam logic [23:0] RST_TIMEOUT         = 24'd375000;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_BIT_RISE  = 4'd1;
  localparam logic [3:0] PH_BIT_FALL  = 4'd2;
  localparam logic [3:0] PH_ACK_LOW   = 4'd3;
  localparam logic [3:0] PH_ACK_HIGH  = 4'd4;
  localparam logic [3:0] PH_ACK_RISE  = 4'd5;
  localparam logic [3:0] PH_ACK_FALL  = 4'd6;
  localparam logic [3:0] PH_WAIT_STOP = 4'd7;
  localparam logic [3:0] PH_STOP_SDA  = 4'd8;
  localparam logic [3:0] PH_STOP_SCL  = 4'd9;

  // Byte kinds
  localparam logic [1:0] KIND_ADDR = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  typedef struct packed {
    logic [7:0]  target_address;
    logic [7:0]  target_register;
    logic [2:0]  inject_pos;
    logic [15:0] ack_delay_ticks;
    logic [23:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic msda_low;
    logic tsda_low;
    logic tscl_low;
  } drive_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [1:0]  byte_kind;
    logic [3:0]  bit_count;
    logic [7:0]  shift_byte;
    logic        address_matched;
    logic        rewrite_enable;
    logic        inject_latched;
    logic [15:0] delay_count;
    logic [23:0] timeout_count;
    logic        timer_running;
    logic        prev_scl;
    logic        prev_sda;
    drive_t      drive;
    logic        scl_release_pending;
  } state_t;

  typedef struct packed {
    logic master_scl;
    logic master_sda;
    logic target_sda;
    logic inject_level;
  } sample_t;

  typedef struct packed {
    logic target_scl_low;
    logic target_sda_low;
    logic master_sda_low;
    logic timed_out;
    logic bit_injected;
  } result_t;

  localparam state_t STATE_RST = '{
    phase:               PH_IDLE,
    byte_kind:           KIND_ADDR,
    bit_count:           4'd0,
    shift_byte:          8'd0,
    address_matched:     1'b0,
    rewrite_enable:      1'b0,
    inject_latched:      1'b1,
    delay_count:         16'd0,
    timeout_count:       24'd0,
    timer_running:       1'b0,
    prev_scl:            1'b1,
    prev_sda:            1'b1,
    drive:               '{msda_low: 1'b0, tsda_low: 1'b0, tscl_low: 1'b0},
    scl_release_pending: 1'b0
  };

endpackage

[sv/i2cwbi_core.sv]
// Next-state and result logic for one tick of bus samples.
module i2cwbi_core (
  input  i2cwbi_pkg::cfg_t    cfg,
  input  i2cwbi_pkg::state_t  cur,
  input  i2cwbi_pkg::sample_t smp,
  output i2cwbi_pkg::state_t  nxt,
  output i2cwbi_pkg::result_t res
);

  logic        rise;
  logic        fall;
  logic        start_cond;
  logic        stop_cond;
  logic [15:0] dly_inc;
  logic        dly_done;
  logic [23:0] tmo_inc;
  logic        tmo_hit;
  logic [3:0]  bit_inc;
  logic [2:0]  bit_pos;
  logic        timed;
  logic        injected;

  assign rise       = ~cur.prev_scl & smp.master_scl;
  assign fall       = cur.prev_scl & ~smp.master_scl;
  assign start_cond = cur.prev_sda & ~smp.master_sda & smp.master_scl;
  assign stop_cond  = ~cur.prev_sda & smp.master_sda & smp.master_scl;
  assign dly_inc    = 16'(cur.delay_count + 16'd1);
  assign dly_done   = dly_inc >= cfg.ack_delay_ticks;
  assign tmo_inc    = 24'(cur.timeout_count + 24'd1);
  assign tmo_hit    = cur.timer_running && (tmo_inc >= cfg.timeout_ticks);
  assign bit_inc    = 4'(cur.bit_count + 4'd1);
  assign bit_pos    = 3'd7 - cur.bit_count[2:0];

  always_comb begin
    nxt      = cur;
    timed    = 1'b0;
    injected = 1'b0;
    if (cur.timer_running) begin
      nxt.timeout_count = tmo_inc;
    end
    if (tmo_hit) begin
      // abort wins over everything else this tick
      nxt.drive               = '0;
      nxt.phase               = i2cwbi_pkg::PH_IDLE;
      nxt.byte_kind           = i2cwbi_pkg::KIND_ADDR;
      nxt.bit_count           = 4'd0;
      nxt.scl_release_pending = 1'b0;
      nxt.delay_count         = 16'd0;
      nxt.timer_running       = 1'b0;
      nxt.timeout_count       = 24'd0;
      timed                   = 1'b1;
    end else begin
      unique case (cur.phase)
        i2cwbi_pkg::PH_BIT_RISE: begin
          nxt.drive.tscl_low = 1'b1;
          if (rise) begin
            if (cur.byte_kind[1] && cur.rewrite_enable && bit_pos == cfg.inject_pos) begin
              nxt.drive.tsda_low = ~cur.inject_latched;
              injected           = 1'b1;
            end else begin
              nxt.drive.tsda_low = ~smp.master_sda;
            end
            nxt.shift_byte          = {cur.shift_byte[6:0], smp.master_sda};
            nxt.scl_release_pending = 1'b1;
            nxt.phase               = i2cwbi_pkg::PH_BIT_FALL;
          end
        end
        i2cwbi_pkg::PH_BIT_FALL: begin
          if (fall) begin
            nxt.drive.tscl_low      = 1'b1;
            nxt.scl_release_pending = 1'b0;
            nxt.bit_count           = bit_inc;
            if (bit_inc >= 4'd8) begin
              nxt.drive.tsda_low = 1'b0;
              if (cur.byte_kind == i2cwbi_pkg::KIND_ADDR) begin
                nxt.address_matched = (cur.shift_byte == cfg.target_address);
              end
              nxt.delay_count = 16'd0;
              nxt.phase       = i2cwbi_pkg::PH_ACK_LOW;
            end else begin
              nxt.phase = i2cwbi_pkg::PH_BIT_RISE;
            end
          end else if (cur.scl_release_pending) begin
            nxt.drive.tscl_low      = 1'b0;
            nxt.scl_release_pending = 1'b0;
          end
        end
        i2cwbi_pkg::PH_ACK_LOW: begin
          nxt.delay_count = dly_done ? 16'd0 : dly_inc;
          if (dly_done) begin
            nxt.drive.tscl_low = 1'b0;
            nxt.phase          = i2cwbi_pkg::PH_ACK_HIGH;
          end
        end
        i2cwbi_pkg::PH_ACK_HIGH: begin
          nxt.delay_count = dly_done ? 16'd0 : dly_inc;
          if (dly_done) begin
            if (cur.byte_kind != i2cwbi_pkg::KIND_ADDR || cur.address_matched) begin
              nxt.drive.msda_low = ~smp.target_sda;
            end
            nxt.phase = i2cwbi_pkg::PH_ACK_RISE;
          end
        end
        i2cwbi_pkg::PH_ACK_RISE: begin
          if (rise) begin
            nxt.phase = i2cwbi_pkg::PH_ACK_FALL;
          end
        end
        i2cwbi_pkg::PH_ACK_FALL: begin
          if (fall) begin
            nxt.drive.tscl_low = 1'b1;
            nxt.drive.msda_low = 1'b0;
            if (cur.byte_kind == i2cwbi_pkg::KIND_ADDR) begin
              if (cur.address_matched) begin
                nxt.byte_kind           = i2cwbi_pkg::KIND_REG;
                nxt.bit_count           = 4'd0;
                nxt.shift_byte          = 8'd0;
                nxt.scl_release_pending = 1'b0;
                nxt.phase               = i2cwbi_pkg::PH_BIT_RISE;
              end else begin
                nxt.timer_running = 1'b0;
                nxt.timeout_count = 24'd0;
                nxt.phase         = i2cwbi_pkg::PH_WAIT_STOP;
              end
            end else if (cur.byte_kind == i2cwbi_pkg::KIND_REG) begin
              nxt.rewrite_enable      = (cur.shift_byte == cfg.target_register);
              nxt.inject_latched      = smp.inject_level;
              nxt.byte_kind           = i2cwbi_pkg::KIND_DATA;
              nxt.bit_count           = 4'd0;
              nxt.shift_byte          = 8'd0;
              nxt.scl_release_pending = 1'b0;
              nxt.phase               = i2cwbi_pkg::PH_BIT_RISE;
            end else begin
              nxt.phase = i2cwbi_pkg::PH_WAIT_STOP;
            end
          end
        end
        i2cwbi_pkg::PH_WAIT_STOP: begin
          if (stop_cond) begin
            nxt.drive.tsda_low = 1'b1;
            nxt.delay_count    = 16'd0;
            nxt.phase          = i2cwbi_pkg::PH_STOP_SDA;
          end
        end
        i2cwbi_pkg::PH_STOP_SDA: begin
          nxt.delay_count = dly_done ? 16'd0 : dly_inc;
          if (dly_done) begin
            nxt.drive.tscl_low = 1'b0;
            nxt.phase          = i2cwbi_pkg::PH_STOP_SCL;
          end
        end
        i2cwbi_pkg::PH_STOP_SCL: begin
          nxt.delay_count = dly_done ? 16'd0 : dly_inc;
          if (dly_done) begin
            nxt.drive.tsda_low = 1'b0;
            nxt.timer_running  = 1'b0;
            nxt.timeout_count  = 24'd0;
            nxt.phase          = i2cwbi_pkg::PH_IDLE;
          end
        end
        default: begin
          // idle, and any unused code
          nxt.phase = i2cwbi_pkg::PH_IDLE;
          if (start_cond) begin
            nxt.drive               = '{msda_low: 1'b0, tsda_low: 1'b1, tscl_low: 1'b0};
            nxt.timeout_count       = 24'd0;
            nxt.timer_running       = 1'b1;
            nxt.address_matched     = 1'b0;
            nxt.rewrite_enable      = 1'b0;
            nxt.byte_kind           = i2cwbi_pkg::KIND_ADDR;
            nxt.bit_count           = 4'd0;
            nxt.shift_byte          = 8'd0;
            nxt.scl_release_pending = 1'b0;
            nxt.phase               = i2cwbi_pkg::PH_BIT_RISE;
          end
        end
      endcase
    end
    nxt.prev_scl = smp.master_scl;
    nxt.prev_sda = smp.master_sda;
  end

  assign res.target_scl_low = nxt.drive.tscl_low;
  assign res.target_sda_low = nxt.drive.tsda_low;
  assign res.master_sda_low = nxt.drive.msda_low;
  assign res.timed_out      = timed;
  assign res.bit_injected   = injected;

endmodule

[sv/i2c_write_bit_injector_unit.sv]
// Top level of the I2C write-bit injector: config registers, state, beat handshake.
// Each input beat is one tick of sampled bus lines and yields exactly one result beat
// with the drive levels after that tick. On accept, the core logic updates the state
// registers and writes the result into an output register, backed by a one-entry skid
// register, so a new beat is taken every cycle while the result side keeps up. in_stall
// rises only when the skid register holds a result. Registers sit at byte addresses
// 0x00 target_address, 0x04 target_register, 0x08 inject bit position, 0x0C
// ack_delay_ticks, 0x10 timeout_ticks; write them only while idle.
module i2c_write_bit_injector_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_master_scl,
  input  logic        in_master_sda,
  input  logic        in_target_sda,
  input  logic        in_inject_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_target_scl_low,
  output logic        out_target_sda_low,
  output logic        out_master_sda_low,
  output logic        out_timed_out,
  output logic        out_bit_injected,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [i2cwbi_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [i2cwbi_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [i2cwbi_pkg::CFG_DW-1:0] cfg_prdata,
  output logic        cfg_pready
);

  i2cwbi_pkg::cfg_t    cfg_r;
  i2cwbi_pkg::state_t  st_r;
  i2cwbi_pkg::state_t  st_nxt;
  i2cwbi_pkg::sample_t smp;
  i2cwbi_pkg::result_t res;
  i2cwbi_pkg::result_t out_r;
  i2cwbi_pkg::result_t skid_r;
  logic                out_vld_r;
  logic                skid_vld_r;
  logic                acc;
  logic                take;
  logic                cfg_wr;
  logic [2:0]          reg_idx;

  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_address  <= i2cwbi_pkg::RST_TARGET_ADDRESS;
      cfg_r.target_register <= i2cwbi_pkg::RST_TARGET_REGISTER;
      cfg_r.inject_pos      <= i2cwbi_pkg::RST_INJECT_POS;
      cfg_r.ack_delay_ticks <= i2cwbi_pkg::RST_ACK_DELAY;
      cfg_r.timeout_ticks   <= i2cwbi_pkg::RST_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        i2cwbi_pkg::REG_TARGET_ADDRESS:  cfg_r.target_address  <= cfg_pwdata[7:0];
        i2cwbi_pkg::REG_TARGET_REGISTER: cfg_r.target_register <= cfg_pwdata[7:0];
        i2cwbi_pkg::REG_INJECT_POS:      cfg_r.inject_pos      <= cfg_pwdata[2:0];
        i2cwbi_pkg::REG_ACK_DELAY:       cfg_r.ack_delay_ticks <= cfg_pwdata[15:0];
        i2cwbi_pkg::REG_TIMEOUT:         cfg_r.timeout_ticks   <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      i2cwbi_pkg::REG_TARGET_ADDRESS:  cfg_prdata = {24'd0, cfg_r.target_address};
      i2cwbi_pkg::REG_TARGET_REGISTER: cfg_prdata = {24'd0, cfg_r.target_register};
      i2cwbi_pkg::REG_INJECT_POS:      cfg_prdata = {29'd0, cfg_r.inject_pos};
      i2cwbi_pkg::REG_ACK_DELAY:       cfg_prdata = {16'd0, cfg_r.ack_delay_ticks};
      i2cwbi_pkg::REG_TIMEOUT:         cfg_prdata = {8'd0, cfg_r.timeout_ticks};
      default:                         cfg_prdata = '0;
    endcase
  end

  assign smp.master_scl   = in_master_scl;
  assign smp.master_sda   = in_master_sda;
  assign smp.target_sda   = in_target_sda;
  assign smp.inject_level = in_inject_level;

  i2cwbi_core u_core (
    .cfg (cfg_r),
    .cur (st_r),
    .smp (smp),
    .nxt (st_nxt),
    .res (res)
  );

  assign in_stall  = skid_vld_r;
  assign acc       = in_valid & ~skid_vld_r;
  assign out_valid = out_vld_r;
  assign take      = out_vld_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= i2cwbi_pkg::STATE_RST;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

  // output register plus skid: skid fills only when the output beat is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (take || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= acc;
      end
    end else if (acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_vld_r) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (acc) begin
        out_r <= res;
      end
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign out_target_scl_low = out_r.target_scl_low;
  assign out_target_sda_low = out_r.target_sda_low;
  assign out_master_sda_low = out_r.master_sda_low;
  assign out_timed_out      = out_r.timed_out;
  assign out_bit_injected   = out_r.bit_injected;

endmodule

[tb/tb_i2c_write_bit_injector_unit.sv]
// Self-checking testbench for the I2C write-bit injector, driven tick by tick.
module tb_i2c_write_bit_injector_unit;

  // Shadow copy of the injector: configuration, sequencer state and the result queue.
  class injector_checker;
    logic [7:0]  want_addr;
    logic [7:0]  want_reg;
    logic [2:0]  swap_pos;
    logic [15:0] step_ticks;
    logic [23:0] abort_ticks;

    logic [3:0]  seq_phase;
    logic [1:0]  kind;
    logic [3:0]  nbits;
    logic [7:0]  shreg;
    logic        addr_hit;
    logic        rewrite_on;
    logic        inj_level;
    logic [15:0] step_cnt;
    logic [23:0] abort_cnt;
    logic        timer_on;
    logic        last_scl;
    logic        last_sda;
    i2cwbi_pkg::drive_t drv;
    logic        rel_pending;

    i2cwbi_pkg::result_t pending_drives[$];
    int      mismatches;
    int      n_samples;

    function new();
      want_addr   = i2cwbi_pkg::RST_TARGET_ADDRESS;
      want_reg    = i2cwbi_pkg::RST_TARGET_REGISTER;
      swap_pos    = i2cwbi_pkg::RST_INJECT_POS;
      step_ticks  = i2cwbi_pkg::RST_ACK_DELAY;
      abort_ticks = i2cwbi_pkg::RST_TIMEOUT;
      seq_phase   = i2cwbi_pkg::PH_IDLE;
      kind        = i2cwbi_pkg::KIND_ADDR;
      nbits       = '0;
      shreg       = '0;
      addr_hit    = 1'b0;
      rewrite_on  = 1'b0;
      inj_level   = 1'b1;
      step_cnt    = '0;
      abort_cnt   = '0;
      timer_on    = 1'b0;
      last_scl    = 1'b1;
      last_sda    = 1'b1;
      drv         = '0;
      rel_pending = 1'b0;
      mismatches  = 0;
      n_samples   = 0;
    endfunction

    function void set_config(logic [2:0] idx, logic [31:0] val);
      case (idx)
        i2cwbi_pkg::REG_TARGET_ADDRESS:  want_addr   = val[7:0];
        i2cwbi_pkg::REG_TARGET_REGISTER: want_reg    = val[7:0];
        i2cwbi_pkg::REG_INJECT_POS:      swap_pos    = val[2:0];
        i2cwbi_pkg::REG_ACK_DELAY:       step_ticks  = val[15:0];
        i2cwbi_pkg::REG_TIMEOUT:         abort_ticks = val[23:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction

    // a zero step count fires after one tick, same as one
    function logic step_elapsed();
      step_cnt = step_cnt + 16'd1;
      if (step_cnt >= step_ticks) begin
        step_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void begin_byte(logic [1:0] k);
      kind        = k;
      nbits       = '0;
      shreg       = '0;
      rel_pending = 1'b0;
      seq_phase   = i2cwbi_pkg::PH_BIT_RISE;
    endfunction

    function i2cwbi_pkg::result_t predict_drive(i2cwbi_pkg::sample_t s);
      logic       rise;
      logic       fall;
      logic       lvl;
      logic       aborted;
      logic [2:0] pos;
      i2cwbi_pkg::result_t r;
      rise    = !last_scl && s.master_scl;
      fall    = last_scl && !s.master_scl;
      r       = '0;
      aborted = 1'b0;

      // timeout wins over everything else on its tick
      if (timer_on) begin
        abort_cnt = abort_cnt + 24'd1;
        if (abort_cnt >= abort_ticks) begin
          drv         = '0;
          seq_phase   = i2cwbi_pkg::PH_IDLE;
          kind        = i2cwbi_pkg::KIND_ADDR;
          nbits       = '0;
          rel_pending = 1'b0;
          step_cnt    = '0;
          timer_on    = 1'b0;
          abort_cnt   = '0;
          r.timed_out = 1'b1;
          aborted     = 1'b1;
        end
      end

      if (!aborted) begin
        case (seq_phase)
          i2cwbi_pkg::PH_BIT_RISE: begin
            drv.tscl_low = 1'b1;
            if (rise) begin
              lvl = s.master_sda;
              pos = 3'd7 - nbits[2:0];
              if (kind >= i2cwbi_pkg::KIND_DATA && rewrite_on && pos == swap_pos) begin
                lvl            = inj_level;
                r.bit_injected = 1'b1;
              end
              drv.tsda_low = ~lvl;
              shreg        = {shreg[6:0], s.master_sda};
              rel_pending  = 1'b1;
              seq_phase    = i2cwbi_pkg::PH_BIT_FALL;
            end
          end
          i2cwbi_pkg::PH_BIT_FALL: begin
            if (fall) begin
              drv.tscl_low = 1'b1;
              rel_pending  = 1'b0;
              nbits        = nbits + 4'd1;
              if (nbits >= 4'd8) begin
                drv.tsda_low = 1'b0;
                if (kind == i2cwbi_pkg::KIND_ADDR) addr_hit = (shreg == want_addr);
                step_cnt  = '0;
                seq_phase = i2cwbi_pkg::PH_ACK_LOW;
              end else begin
                seq_phase = i2cwbi_pkg::PH_BIT_RISE;
              end
            end else if (rel_pending) begin
              drv.tscl_low = 1'b0;
              rel_pending  = 1'b0;
            end
          end
          i2cwbi_pkg::PH_ACK_LOW: begin
            if (step_elapsed()) begin
              drv.tscl_low = 1'b0;
              seq_phase    = i2cwbi_pkg::PH_ACK_HIGH;
            end
          end
          i2cwbi_pkg::PH_ACK_HIGH: begin
            if (step_elapsed()) begin
              if (kind != i2cwbi_pkg::KIND_ADDR || addr_hit) drv.msda_low = ~s.target_sda;
              seq_phase = i2cwbi_pkg::PH_ACK_RISE;
            end
          end
          i2cwbi_pkg::PH_ACK_RISE: begin
            if (rise) seq_phase = i2cwbi_pkg::PH_ACK_FALL;
          end
          i2cwbi_pkg::PH_ACK_FALL: begin
            if (fall) begin
              drv.tscl_low = 1'b1;
              drv.msda_low = 1'b0;
              if (kind == i2cwbi_pkg::KIND_ADDR) begin
                if (addr_hit) begin
                  begin_byte(i2cwbi_pkg::KIND_REG);
                end else begin
                  timer_on  = 1'b0;
                  abort_cnt = '0;
                  seq_phase = i2cwbi_pkg::PH_WAIT_STOP;
                end
              end else if (kind == i2cwbi_pkg::KIND_REG) begin
                rewrite_on = (shreg == want_reg);
                inj_level  = s.inject_level;
                begin_byte(i2cwbi_pkg::KIND_DATA);
              end else begin
                seq_phase = i2cwbi_pkg::PH_WAIT_STOP;
              end
            end
          end
          i2cwbi_pkg::PH_WAIT_STOP: begin
            if (!last_sda && s.master_sda && s.master_scl) begin
              drv.tsda_low = 1'b1;
              step_cnt     = '0;
              seq_phase    = i2cwbi_pkg::PH_STOP_SDA;
            end
          end
          i2cwbi_pkg::PH_STOP_SDA: begin
            if (step_elapsed()) begin
              drv.tscl_low = 1'b0;
              seq_phase    = i2cwbi_pkg::PH_STOP_SCL;
            end
          end
          i2cwbi_pkg::PH_STOP_SCL: begin
            if (step_elapsed()) begin
              drv.tsda_low = 1'b0;
              timer_on     = 1'b0;
              abort_cnt    = '0;
              seq_phase    = i2cwbi_pkg::PH_IDLE;
            end
          end
          default: begin
            seq_phase = i2cwbi_pkg::PH_IDLE;
            if (last_sda && !s.master_sda && s.master_scl) begin
              drv        = '0;
              drv.tsda_low = 1'b1;
              abort_cnt  = '0;
              timer_on   = 1'b1;
              addr_hit   = 1'b0;
              rewrite_on = 1'b0;
              begin_byte(i2cwbi_pkg::KIND_ADDR);
            end
          end
        endcase
      end

      last_scl = s.master_scl;
      last_sda = s.master_sda;
      r.target_scl_low = drv.tscl_low;
      r.target_sda_low = drv.tsda_low;
      r.master_sda_low = drv.msda_low;
      return r;
    endfunction

    function void note_sample(i2cwbi_pkg::sample_t s);
      n_samples++;
      pending_drives.push_back(predict_drive(s));
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_drive(i2cwbi_pkg::result_t got);
      i2cwbi_pkg::result_t exp;
      if (pending_drives.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        exp = pending_drives.pop_front();
        if (got.target_scl_low !== exp.target_scl_low)
          report($sformatf("target_scl_low got %b exp %b", got.target_scl_low,
                           exp.target_scl_low));
        if (got.target_sda_low !== exp.target_sda_low)
          report($sformatf("target_sda_low got %b exp %b", got.target_sda_low,
                           exp.target_sda_low));
        if (got.master_sda_low !== exp.master_sda_low)
          report($sformatf("master_sda_low got %b exp %b", got.master_sda_low,
                           exp.master_sda_low));
        if (got.timed_out !== exp.timed_out)
          report($sformatf("timed_out got %b exp %b", got.timed_out, exp.timed_out));
        if (got.bit_injected !== exp.bit_injected)
          report($sformatf("bit_injected got %b exp %b", got.bit_injected,
                           exp.bit_injected));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_master_scl;
  logic in_master_sda;
  logic in_target_sda;
  logic in_inject_level;
  logic out_valid;
  logic out_stall;
  logic out_target_scl_low;
  logic out_target_sda_low;
  logic out_master_sda_low;
  logic out_timed_out;
  logic out_bit_injected;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [i2cwbi_pkg::CFG_AW-1:0] cfg_paddr;
  logic [i2cwbi_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [i2cwbi_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  injector_checker sb;

  // stimulus view of the current configuration
  logic [7:0]  cur_addr;
  logic [7:0]  cur_reg;
  int          cur_delay;
  bit          quiet_tx;

  i2c_write_bit_injector_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_master_scl      (in_master_scl),
    .in_master_sda      (in_master_sda),
    .in_target_sda      (in_target_sda),
    .in_inject_level    (in_inject_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_target_scl_low (out_target_scl_low),
    .out_target_sda_low (out_target_sda_low),
    .out_master_sda_low (out_master_sda_low),
    .out_timed_out      (out_timed_out),
    .out_bit_injected   (out_bit_injected),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int hold();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 1;
    if (r < 9) return 2;
    return $urandom_range(3, 6);
  endfunction

  // master holds SCL low long enough for both target ack steps
  function automatic int ack_wait();
    int d;
    int w;
    d = (cur_delay == 0) ? 1 : cur_delay;
    w = 2 * d + 1 + $urandom_range(0, 3);
    return (w > 300) ? 300 : w;
  endfunction

  function automatic int stop_idle();
    int d;
    int w;
    d = (cur_delay == 0) ? 1 : cur_delay;
    w = 2 * d + 2;
    return (w > 310) ? 310 : w;
  endfunction

  // result side: checks each accepted beat, then picks the next stall
  initial begin
    int  stall_left;
    bit  quiet_rx;
    stall_left = 0;
    quiet_rx   = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_drive('{target_scl_low: out_target_scl_low,
                         target_sda_low: out_target_sda_low,
                         master_sda_low: out_master_sda_low,
                         timed_out:      out_timed_out,
                         bit_injected:   out_bit_injected});
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet_rx) stall_left = pick_gap();
        if ($urandom_range(0, 199) == 0) quiet_rx = ~quiet_rx;
      end
    end
  end

  task automatic send_beat(input logic scl, input logic sda, input logic tsda,
                           input logic inj);
    int gap;
    gap = quiet_tx ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_master_scl   <= scl;
    in_master_sda   <= sda;
    in_target_sda   <= tsda;
    in_inject_level <= inj;
    do @(posedge clk); while (in_stall);
    sb.note_sample('{master_scl: scl, master_sda: sda, target_sda: tsda,
                     inject_level: inj});
  endtask

  task automatic lines(input logic scl, input logic sda, input int n);
    repeat (n) send_beat(scl, sda, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic i2c_start();
    lines(1'b1, 1'b1, hold());
    lines(1'b1, 1'b0, hold());
  endtask

  task automatic i2c_bit(input logic b);
    lines(1'b0, b, hold());
    lines(1'b1, b, hold());
  endtask

  task automatic i2c_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) i2c_bit(v[i]);
  endtask

  // sloppy masters sometimes clock the ack during the target delay
  task automatic i2c_ack(input bit sloppy);
    int w;
    w = (sloppy && $urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : ack_wait();
    lines(1'b0, 1'b1, w);
    lines(1'b1, 1'b1, hold());
  endtask

  task automatic i2c_stop();
    lines(1'b0, 1'b0, hold());
    lines(1'b1, 1'b0, hold());
    lines(1'b1, 1'b1, hold());
  endtask

  task automatic write_txn(input logic [7:0] a, input logic [7:0] r, input logic [7:0] d,
                           input int extra, input bit sloppy);
    i2c_start();
    i2c_byte(a);
    i2c_ack(sloppy);
    i2c_byte(r);
    i2c_ack(sloppy);
    i2c_byte(d);
    i2c_ack(sloppy);
    repeat (extra) begin
      i2c_byte(8'($urandom));
      i2c_ack(sloppy);
    end
    i2c_stop();
    lines(1'b1, 1'b1, stop_idle());
  endtask

  task automatic noise(input int n);
    repeat (n) lines(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
  endtask

  task automatic broken_txn();
    i2c_start();
    repeat ($urandom_range(1, 20)) i2c_bit(1'($urandom_range(0, 1)));
    case ($urandom_range(0, 3))
      0: i2c_stop();
      1: i2c_start();
      2: lines(1'b0, 1'b1, $urandom_range(1, 3));
      default: noise($urandom_range(3, 12));
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // walk the sequencer back to idle: clock pulses with a STOP in each
  task automatic settle_bus();
    int guard;
    guard = 0;
    while (sb.seq_phase != i2cwbi_pkg::PH_IDLE && guard < 50000) begin
      lines(1'b0, 1'b0, 1);
      lines(1'b1, 1'b0, 1);
      lines(1'b1, 1'b1, 1);
      guard++;
    end
    lines(1'b1, 1'b1, 2);
    drain_results();
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_config(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] a, input logic [7:0] r, input logic [2:0] b,
                             input logic [15:0] d, input logic [23:0] t);
    settle_bus();
    write_reg(i2cwbi_pkg::REG_TARGET_ADDRESS, {24'd0, a});
    write_reg(i2cwbi_pkg::REG_TARGET_REGISTER, {24'd0, r});
    write_reg(i2cwbi_pkg::REG_INJECT_POS, {29'd0, b});
    write_reg(i2cwbi_pkg::REG_ACK_DELAY, {16'd0, d});
    write_reg(i2cwbi_pkg::REG_TIMEOUT, {8'd0, t});
    cur_addr  = a;
    cur_reg   = r;
    cur_delay = d;
  endtask

  task automatic reconfigure_random();
    int          k;
    logic [15:0] d;
    logic [23:0] t;
    k = $urandom_range(0, 9);
    if (k < 7) d = 16'($urandom_range(1, 3));
    else if (k < 9) d = 16'd0;
    else d = 16'($urandom_range(4, 12));
    if ($urandom_range(0, 1) == 0) t = 24'($urandom_range(60, 500));
    else t = 24'($urandom_range(100000, 16777215));
    reconfigure(8'($urandom), 8'($urandom), 3'($urandom_range(0, 7)), d, t);
  endtask

  initial begin
    int iter;
    int guard;
    logic [7:0] a;
    logic [7:0] r;

    sb = new();
    quiet_tx  = 1'b0;
    cur_addr  = i2cwbi_pkg::RST_TARGET_ADDRESS;
    cur_reg   = i2cwbi_pkg::RST_TARGET_REGISTER;
    cur_delay = i2cwbi_pkg::RST_ACK_DELAY;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_master_scl   <= 1'b1;
    in_master_sda   <= 1'b1;
    in_target_sda   <= 1'b1;
    in_inject_level <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short ack steps; address, register and bit keep their reset values:
    // match 0x88 / 0x00, replace the first data bit
    write_reg(i2cwbi_pkg::REG_ACK_DELAY, 32'd4);
    cur_delay = 4;
    write_txn(8'h88, 8'h00, 8'h5A, 0, 1'b0);

    reconfigure(8'h00, 8'hFF, 3'd0, 16'd1, 24'hFFFFFF);
    write_txn(8'h00, 8'hFF, 8'h00, 1, 1'b0);
    write_txn(8'h00, 8'h7E, 8'hFF, 0, 1'b0);   // register miss, no injection
    write_txn(8'h01, 8'hFF, 8'hFF, 0, 1'b0);   // address miss on R/W bit
    // repeated START mid byte is just clocked in as data
    i2c_start();
    repeat (3) i2c_bit(1'b1);
    i2c_start();
    i2c_byte(8'h00);
    // master clocks the ack before the target delay has run out
    settle_bus();
    i2c_start();
    i2c_byte(8'h00);
    lines(1'b0, 1'b1, 1);
    lines(1'b1, 1'b1, 1);
    lines(1'b0, 1'b1, 6);
    lines(1'b1, 1'b1, 2);
    i2c_stop();

    reconfigure(8'hFF, 8'h80, 3'd3, 16'd0, 24'hFFFFFF);   // zero delay
    write_txn(8'hFF, 8'h80, 8'h33, 0, 1'b0);
    reconfigure(8'hFF, 8'h80, 3'd3, 16'd2, 24'd0);        // zero timeout
    i2c_start();
    i2c_byte(8'hFF);
    reconfigure(8'hFF, 8'h80, 3'd3, 16'hFFFF, 24'd150);   // abort while acking
    i2c_start();
    i2c_byte(8'hFF);
    lines(1'b0, 1'b1, 160);
    lines(1'b1, 1'b1, 2);

    reconfigure_random();
    iter = 0;
    while (sb.n_samples < 1750) begin
      quiet_tx = ($urandom_range(0, 4) == 0);
      if (iter == 3) drain_results();
      k_pick: begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          a = ($urandom_range(0, 9) < 8) ? cur_addr : 8'($urandom);
          r = ($urandom_range(0, 9) < 7) ? cur_reg : 8'($urandom);
          write_txn(a, r, 8'($urandom), $urandom_range(0, 1), 1'b1);
        end else if (pick < 80) begin
          broken_txn();
        end else if (pick < 90) begin
          noise($urandom_range(4, 30));
        end else begin
          reconfigure_random();
        end
      end
      iter++;
    end
    quiet_tx = 1'b0;

    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() > 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
